[src/sstl_pkg.sv]
`default_nettype none
package sstl_pkg;

	localparam int STAGES     = 16;
	localparam int IDX_W      = 4;
	localparam int FULL_ITERS = 32;
	localparam int ITER_W     = 6;
	localparam int SEQ_REF    = 12;
	localparam int MULT_REF   = 100;
	localparam int LEN_SHIFT  = 6;
	localparam int MEAS_SHIFT = 5;

	// reciprocal of three, exact for operands below 2^20
	localparam int          DIV3_SHIFT = 21;
	localparam logic [41:0] DIV3_RECIP = 42'd699051;

	// register indexes
	localparam logic [2:0] REG_WALK    = 3'd0;
	localparam logic [2:0] REG_SEQ     = 3'd1;
	localparam logic [2:0] REG_MEASURE = 3'd2;
	localparam logic [2:0] REG_MULT    = 3'd3;
	localparam logic [2:0] REG_SKIP    = 3'd4;
	localparam logic [2:0] REG_CODES   = 3'd5;
	localparam logic [2:0] REG_LEN_LO  = 3'd6;
	localparam logic [2:0] REG_LEN_HI  = 3'd7;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLR,
		OP_MUL_RAW,
		OP_DIV12,
		OP_MUL_LEN,
		OP_MUL_100,
		OP_DIV_MULT,
		OP_ACC,
		OP_IDX_CLR,
		OP_STR_MUL,
		OP_STR_DIV,
		OP_STR_WR,
		OP_TAKE,
		OP_MOD,
		OP_SCAN,
		OP_PHASE
	} op_e;

	typedef struct packed {
		op_e  op;
		logic load_out;
		logic load_zero;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic idx_last;
		logic hit;
		logic cycle_zero;
		logic stretch_need;
	} dp_status_t;

	// grid cell visited at position idx of walk pattern mode
	function automatic logic [3:0] walk_cell(input logic [2:0] mode, input logic [3:0] idx);
		logic [63:0] row;
		case (mode)
			3'd0:    row = 64'hCDEFBA9845673210;
			3'd1:    row = 64'h32107654BA98FEDC;
			3'd2:    row = 64'h0123765489ABFEDC;
			3'd3:    row = 64'h048C159D26AE37BF;
			3'd4:    row = 64'h37BFEA62159DC840;
			3'd5:    row = 64'h56A98401237BFEDC;
			3'd6:    row = 64'hCDEFB7321048A659;
			default: row = 64'h372B61FA50E94D8C;
		endcase
		return row[{idx, 2'b00} +: 4];
	endfunction

	function automatic logic [10:0] slot_ticks(input logic [2:0] code);
		logic [10:0] t;
		case (code)
			3'd0:    t = 11'd48;
			3'd1:    t = 11'd64;
			3'd2:    t = 11'd96;
			3'd3:    t = 11'd128;
			3'd4:    t = 11'd192;
			3'd5:    t = 11'd384;
			3'd6:    t = 11'd768;
			default: t = 11'd1536;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

[src/stage_schedule_tick_locator.sv]
`default_nettype none
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  s_tdata: rel_tick
// m_*       out        m_tvalid/m_tready  m_tdata: valid_res, slot, active_cell, phase, cycle_len
// cfg_*     in         cfg_we             cfg_index, cfg_wdata
//
// an item runs the modulo on the shared bit-serial divider, then scans the slots
// (up to 16) and runs the phase division on the same divider
// reset and every config write start a rebuild of the end table
// (16 stages, one 32-step division each), plus a stretch pass when it is needed
// s_tready is low during rebuild and while an item is in work
// a finished result waits in the output register; the next item is taken meanwhile
module stage_schedule_tick_locator #(
	parameter int PHASE_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // rel_tick
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata    // valid_res, slot[4], active_cell[4], phase[16], cycle_len[31]
);

	sstl_pkg::dp_cmd_t    cmd;
	sstl_pkg::dp_status_t st;

	// sequencing of rebuild and item work
	sstl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// config, end table, multiplier, divider and result register
	sstl_dp #(
		.PHASE_BITS (PHASE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.tick      (s_tdata),
		.cmd       (cmd),
		.status    (st),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire

[src/sstl_div.sv]
`default_nettype none
module sstl_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	input  wire logic [31:0] rem_init,
	input  wire logic [sstl_pkg::ITER_W-1:0] iters,
	output logic             busy,
	output logic [31:0]      quot,
	output logic [31:0]      rem
);

	logic [sstl_pkg::ITER_W-1:0] cnt_q;
	logic [31:0] dvd_q, dsr_q, rem_q, quo_q;
	logic [32:0] r_sh, r_sub;
	logic        ge;

	// one restoring step per cycle
	assign r_sh  = {rem_q, dvd_q[31]};
	assign ge    = r_sh >= {1'b0, dsr_q};
	assign r_sub = r_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= iters;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= rem_init;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= ge ? r_sub[31:0] : r_sh[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

[src/sstl_dp.sv]
`default_nettype none
module sstl_dp #(
	parameter int PHASE_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_wdata,
	input  wire logic [31:0] tick,
	input  wire sstl_pkg::dp_cmd_t cmd,
	output sstl_pkg::dp_status_t   status,
	output logic [55:0]      out_data
);

	localparam logic [5:0] PH_ITERS = 6'(PHASE_BITS);

	logic [3:0]  walk_mode_q;
	logic [10:0] seq_div_q;
	logic [15:0] measure_div_q;
	logic [9:0]  clock_mult_q;
	logic [15:0] skip_mask_q;
	logic [47:0] slot_codes_q;
	logic [63:0] lengths_low_q, lengths_high_q;

	logic [31:0] ends_q [sstl_pkg::STAGES];
	logic [31:0] acc_q, cycle_q, mul_q, tick_q, prev_q;
	logic [3:0]  idx_q;

	// config registers with reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_mode_q    <= 4'd0;
			seq_div_q      <= 11'd12;
			measure_div_q  <= 16'd0;
			clock_mult_q   <= 10'd100;
			skip_mask_q    <= 16'd0;
			slot_codes_q   <= 48'd241264265751990;
			lengths_low_q  <= 64'h4040404040404040;
			lengths_high_q <= 64'h4040404040404040;
		end else if (cfg_we) begin
			case (cfg_index)
				sstl_pkg::REG_WALK:    walk_mode_q    <= cfg_wdata[3:0];
				sstl_pkg::REG_SEQ:     seq_div_q      <= cfg_wdata[10:0];
				sstl_pkg::REG_MEASURE: measure_div_q  <= cfg_wdata[15:0];
				sstl_pkg::REG_MULT:    clock_mult_q   <= cfg_wdata[9:0];
				sstl_pkg::REG_SKIP:    skip_mask_q    <= cfg_wdata[15:0];
				sstl_pkg::REG_CODES:   slot_codes_q   <= cfg_wdata[47:0];
				sstl_pkg::REG_LEN_LO:  lengths_low_q  <= cfg_wdata;
				default:               lengths_high_q <= cfg_wdata;
			endcase
		end
	end

	logic [3:0]  grid_cell;
	logic        skipped;
	logic [10:0] raw;
	logic [11:0] seq;
	logic [9:0]  mult;
	logic [6:0]  len7;
	logic [10:0] minc;
	logic [31:0] end_rd;
	logic [31:0] mul_a;
	logic [11:0] mul_b;
	logic [43:0] mul_p;
	logic [41:0] d12_p;

	assign grid_cell = sstl_pkg::walk_cell(walk_mode_q[2:0], idx_q);
	assign skipped   = skip_mask_q[grid_cell];
	assign raw       = (!walk_mode_q[3] && skipped) ? 11'd0
	                 : sstl_pkg::slot_ticks(
	                       slot_codes_q[{grid_cell, 1'b0} + {2'b00, grid_cell} +: 3]);
	assign seq       = (seq_div_q == '0) ? 12'(sstl_pkg::SEQ_REF) : {1'b0, seq_div_q};
	assign mult      = (clock_mult_q == '0) ? 10'(sstl_pkg::MULT_REF) : clock_mult_q;
	assign len7      = grid_cell[3] ? lengths_high_q[{grid_cell[2:0], 3'b000} +: 7]
	                                : lengths_low_q[{grid_cell[2:0], 3'b000} +: 7];
	assign minc      = measure_div_q[15:sstl_pkg::MEAS_SHIFT];
	assign end_rd    = ends_q[idx_q];

	// floor(x / 12): drop two bits, then multiply by the reciprocal of three
	assign d12_p = {22'd0, mul_q[21:2]} * sstl_pkg::DIV3_RECIP;

	logic        div_start, div_busy;
	logic [31:0] div_dvd, div_dsr, div_rem0, div_quot, div_rem;
	logic [5:0]  div_iters;

	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_dvd   = mul_q;
		div_dsr   = cycle_q;
		div_rem0  = '0;
		div_iters = 6'(sstl_pkg::FULL_ITERS);
		case (cmd.op)
			sstl_pkg::OP_MUL_RAW: begin
				mul_a = {21'd0, raw};
				mul_b = seq;
			end
			sstl_pkg::OP_MUL_LEN: begin
				mul_a = mul_q;
				mul_b = {5'd0, len7};
			end
			sstl_pkg::OP_MUL_100: begin
				mul_a = mul_q >> sstl_pkg::LEN_SHIFT;
				mul_b = 12'(sstl_pkg::MULT_REF);
			end
			sstl_pkg::OP_STR_MUL: begin
				mul_a = end_rd;
				mul_b = {1'b0, minc};
			end
			sstl_pkg::OP_DIV_MULT: begin
				div_start = 1'b1;
				div_dsr   = {22'd0, mult};
			end
			sstl_pkg::OP_STR_DIV: begin
				div_start = 1'b1;
				div_dvd   = mul_q + {1'b0, cycle_q[31:1]};
			end
			sstl_pkg::OP_MOD: begin
				div_start = 1'b1;
				div_dvd   = tick_q;
			end
			sstl_pkg::OP_PHASE: begin
				div_start = 1'b1;
				div_dvd   = '0;
				div_dsr   = end_rd - prev_q;
				div_rem0  = div_rem - prev_q;
				div_iters = PH_ITERS;
			end
			default: begin
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	sstl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.rem_init (div_rem0),
		.iters    (div_iters),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else begin
			case (cmd.op)
				sstl_pkg::OP_CLR, sstl_pkg::OP_IDX_CLR, sstl_pkg::OP_TAKE: idx_q <= '0;
				sstl_pkg::OP_ACC, sstl_pkg::OP_STR_WR: idx_q <= idx_q + 1'b1;
				sstl_pkg::OP_SCAN: if (!status.hit) idx_q <= idx_q + 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			sstl_pkg::OP_CLR: acc_q <= '0;
			sstl_pkg::OP_MUL_RAW, sstl_pkg::OP_MUL_LEN, sstl_pkg::OP_MUL_100,
			sstl_pkg::OP_STR_MUL: mul_q <= mul_p[31:0];
			sstl_pkg::OP_DIV12: mul_q <= {12'd0, d12_p[sstl_pkg::DIV3_SHIFT +: 20]};
			sstl_pkg::OP_ACC: begin
				acc_q         <= acc_q + div_quot;
				cycle_q       <= acc_q + div_quot;
				ends_q[idx_q] <= acc_q + div_quot;
			end
			sstl_pkg::OP_STR_WR: begin
				ends_q[idx_q] <= div_quot;
				if (status.idx_last) cycle_q <= div_quot;
			end
			sstl_pkg::OP_TAKE: begin
				tick_q <= tick;
				prev_q <= '0;
			end
			sstl_pkg::OP_SCAN: if (!status.hit) prev_q <= end_rd;
			default: begin
			end
		endcase
	end

	// result payload: valid, slot, cell, phase, cycle from bit 0 up
	always_ff @(posedge clk) begin
		if (cmd.load_zero) begin
			out_data <= '0;
		end else if (cmd.load_out) begin
			out_data <= {cycle_q[30:0], div_quot[15:0],
			             sstl_pkg::walk_cell(walk_mode_q[2:0], idx_q), idx_q, 1'b1};
		end
	end

	assign status.div_busy     = div_busy;
	assign status.idx_last     = idx_q == 4'(sstl_pkg::STAGES - 1);
	assign status.hit          = div_rem < end_rd;
	assign status.cycle_zero   = cycle_q == '0;
	assign status.stretch_need = (cycle_q != '0) && (minc != '0) && (cycle_q < {21'd0, minc});

endmodule
`default_nettype wire

[src/sstl_ctrl.sv]
`default_nettype none
module sstl_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	input  wire sstl_pkg::dp_status_t st,
	output sstl_pkg::dp_cmd_t         cmd
);

	typedef enum logic [4:0] {
		RB_CLR, RB_RAW, RB_D12, RB_LEN, RB_M100, RB_DM, RB_DMW, RB_ACC,
		RB_CHK, ST_MUL, ST_DIV, ST_DIVW, ST_WR,
		IDLE, IT_MOD, IT_MODW, IT_SCAN, IT_PHW, IT_OUT, IT_ZERO
	} state_t;

	state_t state_q;
	logic   out_free;

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = state_q == IDLE;

	always_comb begin
		cmd.op        = sstl_pkg::OP_NONE;
		cmd.load_out  = 1'b0;
		cmd.load_zero = 1'b0;
		case (state_q)
			RB_CLR:  cmd.op = sstl_pkg::OP_CLR;
			RB_RAW:  cmd.op = sstl_pkg::OP_MUL_RAW;
			RB_D12:  cmd.op = sstl_pkg::OP_DIV12;
			RB_LEN:  cmd.op = sstl_pkg::OP_MUL_LEN;
			RB_M100: cmd.op = sstl_pkg::OP_MUL_100;
			RB_DM:   cmd.op = sstl_pkg::OP_DIV_MULT;
			RB_ACC:  cmd.op = sstl_pkg::OP_ACC;
			RB_CHK:  cmd.op = sstl_pkg::OP_IDX_CLR;
			ST_MUL:  cmd.op = sstl_pkg::OP_STR_MUL;
			ST_DIV:  cmd.op = sstl_pkg::OP_STR_DIV;
			ST_WR:   cmd.op = sstl_pkg::OP_STR_WR;
			IDLE:    if (s_tvalid) cmd.op = sstl_pkg::OP_TAKE;
			IT_MOD:  cmd.op = sstl_pkg::OP_MOD;
			IT_SCAN: cmd.op = st.hit ? sstl_pkg::OP_PHASE : sstl_pkg::OP_SCAN;
			IT_OUT:  cmd.load_out = out_free;
			IT_ZERO: cmd.load_zero = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= RB_CLR;
			m_tvalid <= 1'b0;
		end else begin
			if (cmd.load_out || cmd.load_zero) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			if (cfg_we) begin
				state_q <= RB_CLR;
			end else begin
				case (state_q)
					RB_CLR:  state_q <= RB_RAW;
					RB_RAW:  state_q <= RB_D12;
					RB_D12:  state_q <= RB_LEN;
					RB_LEN:  state_q <= RB_M100;
					RB_M100: state_q <= RB_DM;
					RB_DM:   state_q <= RB_DMW;
					RB_DMW:  if (!st.div_busy) state_q <= RB_ACC;
					RB_ACC:  state_q <= st.idx_last ? RB_CHK : RB_RAW;
					RB_CHK:  state_q <= st.stretch_need ? ST_MUL : IDLE;
					ST_MUL:  state_q <= ST_DIV;
					ST_DIV:  state_q <= ST_DIVW;
					ST_DIVW: if (!st.div_busy) state_q <= ST_WR;
					ST_WR:   state_q <= st.idx_last ? IDLE : ST_MUL;
					IDLE:    if (s_tvalid) state_q <= st.cycle_zero ? IT_ZERO : IT_MOD;
					IT_MOD:  state_q <= IT_MODW;
					IT_MODW: if (!st.div_busy) state_q <= IT_SCAN;
					IT_SCAN: if (st.hit) state_q <= IT_PHW;
					IT_PHW:  if (!st.div_busy) state_q <= IT_OUT;
					IT_OUT:  if (out_free) state_q <= IDLE;
					IT_ZERO: if (out_free) state_q <= IDLE;
					default: state_q <= IDLE;
				endcase
			end
		end
	end

endmodule
`default_nettype wire
